// ===== design/des_key_schedule_unit_assert.svh =====
// assertion macros used by the checker file of the des key schedule unit
// no dependencies; expects i_clk and i_rst_n in the including scope
`ifndef DES_KEY_SCHEDULE_UNIT_ASSERT_SVH
`define DES_KEY_SCHEDULE_UNIT_ASSERT_SVH

// same-cycle implication, clocked on i_clk, quiet during reset
`define DKS_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("des key schedule check failed");

// next-cycle implication, clocked on i_clk, quiet during reset
`define DKS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("des key schedule check failed");

`endif

// ===== design/des_ks_pkg.sv =====
// types, constants and permutation functions for the des key schedule unit
// no dependencies; used by every module of the block
`default_nettype none

package des_ks_pkg;

    // round count and derived widths
    localparam int unsigned ROUNDS      = 16;
    localparam int unsigned RND_W       = 4;
    localparam int unsigned NUM_W       = 5;
    localparam int unsigned KEY_W       = 64;
    localparam int unsigned HALF_W      = 28;
    localparam int unsigned CD_W        = 56;
    localparam int unsigned SUBKEY_W    = 48;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned PTR_W       = 1;
    localparam int unsigned CNT_W       = 2;

    // key permutation, positions counted upwards from one at the key msb
    localparam logic [6:0] PC1_SEL [CD_W] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    // compression permutation, positions counted upwards from one at the c||d msb
    localparam logic [6:0] PC2_SEL [SUBKEY_W] = '{
        7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28,
        7'd15, 7'd6,  7'd21, 7'd10, 7'd23, 7'd19, 7'd12, 7'd4,
        7'd26, 7'd8,  7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
        7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55, 7'd30, 7'd40,
        7'd51, 7'd45, 7'd33, 7'd48, 7'd44, 7'd49, 7'd39, 7'd56,
        7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
    };

    // left rotation per round
    localparam logic [1:0] ROT_AMT [ROUNDS] = '{
        2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
    };

    // push request from the front into the queue
    typedef struct packed {
        logic            valid;
        logic [CD_W-1:0] cd;
    } t_cd_req;

    // queue status towards front and back
    typedef struct packed {
        logic            full;
        logic            valid;
        logic [CD_W-1:0] cd;
    } t_q_stat;

    // select 56 key bits into c||d, first selected bit in the msb
    function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] key);
        logic [CD_W-1:0] res;
        logic [6:0]      pos;
        res = '0;
        for (int i = 0; i < CD_W; i++) begin
            pos = 7'd64 - PC1_SEL[i];
            res[CD_W-1-i] = key[pos[5:0]];
        end
        return res;
    endfunction

    // select 48 bits of c||d into the round key, first selected bit in the msb
    function automatic logic [SUBKEY_W-1:0] pc2(input logic [CD_W-1:0] cd);
        logic [SUBKEY_W-1:0] res;
        logic [6:0]          pos;
        res = '0;
        for (int i = 0; i < SUBKEY_W; i++) begin
            pos = 7'd56 - PC2_SEL[i];
            res[SUBKEY_W-1-i] = cd[pos[5:0]];
        end
        return res;
    endfunction

    // rotate both 28-bit halves left by one or two places
    function automatic logic [CD_W-1:0] rot_cd(input logic [CD_W-1:0] cd,
                                               input logic [1:0]      amt);
        logic [HALF_W-1:0] c;
        logic [HALF_W-1:0] d;
        c = cd[CD_W-1:HALF_W];
        d = cd[HALF_W-1:0];
        if (amt == 2'd2) begin
            c = {c[HALF_W-3:0], c[HALF_W-1:HALF_W-2]};
            d = {d[HALF_W-3:0], d[HALF_W-1:HALF_W-2]};
        end else begin
            c = {c[HALF_W-2:0], c[HALF_W-1]};
            d = {d[HALF_W-2:0], d[HALF_W-1]};
        end
        return {c, d};
    endfunction

endpackage

`default_nettype wire

// ===== design/des_key_schedule_unit.sv =====
// DES key schedule unit: one 64-bit key in, sixteen 48-bit round keys out
// depends on des_ks_pkg, des_ks_front, des_ks_queue and des_ks_back
//
// s_axis carries one key per request in tdata (bit 63 is key bit 1, parity
// bits ignored). m_axis returns the round keys of each key in round order:
// tdata holds the 48-bit round key, tuser the round number 1 to 16 and
// tlast marks round 16.
// the key permutation is applied as the key is taken and the result waits in
// a two-entry queue; while the output is not stalled, the round engine rotates
// c and d and applies the compression permutation once per cycle into the
// output register, after the key has passed the queue and the c||d register.
// throughput: one round key per cycle while the output is not stalled, set by
// the single round engine; the queue lets up to two further keys be taken
// while a key is still being expanded.
// when m_axis_tready is low the output beat holds and the engine pauses;
// s_axis_tready falls only when the queue is full.
// reset (i_rst_n low, synchronous) empties the queue and drops any beat in
// flight and idles the round engine; the payload registers are not reset.
`default_nettype none

module des_key_schedule_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [des_ks_pkg::KEY_W-1:0]       s_axis_tdata,   // [63:0] cipher_key
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [des_ks_pkg::SUBKEY_W-1:0]         m_axis_tdata,   // [47:0] round_key
    output logic [des_ks_pkg::NUM_W-1:0]            m_axis_tuser,   // [4:0] round_number
    output logic                                    m_axis_tlast    // last_key
);

    des_ks_pkg::t_cd_req push;
    des_ks_pkg::t_q_stat q_stat;
    logic                pop;

    // key intake and key permutation
    des_ks_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_q_stat      (q_stat),
        .o_push        (push)
    );

    // decoupling queue
    des_ks_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_stat  (q_stat)
    );

    // round engine and output register
    des_ks_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== design/des_ks_front.sv =====
// front end: takes key requests and applies the key permutation
// depends on des_ks_pkg; feeds des_ks_queue
`default_nettype none

module des_ks_front (
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [des_ks_pkg::KEY_W-1:0]    s_axis_tdata,   // [63:0] cipher_key
    input  wire des_ks_pkg::t_q_stat             i_q_stat,
    output des_ks_pkg::t_cd_req                  o_push
);

    // accept whenever the queue has room
    assign s_axis_tready = !i_q_stat.full;

    // reduce the key to c||d on the way in
    always_comb begin
        o_push.valid = s_axis_tvalid && !i_q_stat.full;
        o_push.cd    = des_ks_pkg::pc1(s_axis_tdata);
    end

endmodule

`default_nettype wire

// ===== design/des_ks_queue.sv =====
// two-entry queue of c||d values between front and round engine
// depends on des_ks_pkg
`default_nettype none

module des_ks_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire des_ks_pkg::t_cd_req   i_push,
    input  wire logic                  i_pop,
    output des_ks_pkg::t_q_stat        o_stat
);

    logic [des_ks_pkg::CD_W-1:0]  r_mem [des_ks_pkg::QUEUE_DEPTH];
    logic [des_ks_pkg::PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [des_ks_pkg::PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [des_ks_pkg::CNT_W-1:0] r_count, n_count;
    logic                         do_pop;

    // pointer and fill count update
    always_comb begin
        do_pop   = i_pop && (r_count != '0);
        n_wr_ptr = i_push.valid ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.cd;
        end
    end

    // status towards both sides
    always_comb begin
        o_stat.full  = (r_count == des_ks_pkg::CNT_W'(des_ks_pkg::QUEUE_DEPTH));
        o_stat.valid = (r_count != '0);
        o_stat.cd    = r_mem[r_rd_ptr];
    end

endmodule

`default_nettype wire

// ===== design/des_ks_back.sv =====
// round engine: rotates and applies pc2 once per unstalled cycle into an output register
// depends on des_ks_pkg; drains des_ks_queue
`default_nettype none

module des_ks_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire des_ks_pkg::t_q_stat                i_q_stat,
    output logic                                    o_pop,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [des_ks_pkg::SUBKEY_W-1:0]         m_axis_tdata,   // [47:0] round_key
    output logic [des_ks_pkg::NUM_W-1:0]            m_axis_tuser,   // [4:0] round_number
    output logic                                    m_axis_tlast    // last_key
);

    logic                              r_busy, n_busy;
    logic [des_ks_pkg::RND_W-1:0]      r_round, n_round;
    logic [des_ks_pkg::CD_W-1:0]       r_cd, n_cd;
    logic                              r_out_valid, n_out_valid;
    logic [des_ks_pkg::SUBKEY_W-1:0]   r_key, n_key;
    logic [des_ks_pkg::NUM_W-1:0]      r_num, n_num;
    logic                              r_last, n_last;
    logic                              advance;
    logic                              final_rnd;
    logic [des_ks_pkg::CD_W-1:0]       step_cd;

    // next round and next output beat
    always_comb begin
        step_cd   = des_ks_pkg::rot_cd(r_cd, des_ks_pkg::ROT_AMT[r_round]);
        final_rnd = (r_round == des_ks_pkg::RND_W'(des_ks_pkg::ROUNDS - 1));
        advance   = r_busy && (!r_out_valid || m_axis_tready);

        n_busy      = r_busy;
        n_round     = r_round;
        n_cd        = r_cd;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_key       = r_key;
        n_num       = r_num;
        n_last      = r_last;

        // produce one round key
        if (advance) begin
            n_cd        = step_cd;
            n_round     = r_round + 1'b1;
            n_out_valid = 1'b1;
            n_key       = des_ks_pkg::pc2(step_cd);
            n_num       = {1'b0, r_round} + 1'b1;
            n_last      = final_rnd;
            if (final_rnd) begin
                n_busy = 1'b0;
            end
        end

        // take the next key when idle or finishing the last round
        o_pop = i_q_stat.valid && (!r_busy || (advance && final_rnd));
        if (o_pop) begin
            n_busy  = 1'b1;
            n_round = '0;
            n_cd    = i_q_stat.cd;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cd   <= n_cd;
        r_key  <= n_key;
        r_num  <= n_num;
        r_last <= n_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_key;
    assign m_axis_tuser  = r_num;
    assign m_axis_tlast  = r_last;

endmodule

`default_nettype wire

// ===== design/des_ks_checker.sv =====
// port-level checks for the des key schedule unit, bound to the top level
// depends on des_ks_pkg and des_key_schedule_unit_assert.svh
`default_nettype none

`include "des_key_schedule_unit_assert.svh"

module des_ks_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [des_ks_pkg::SUBKEY_W-1:0]    m_axis_tdata,
    input wire logic [des_ks_pkg::NUM_W-1:0]       m_axis_tuser,
    input wire logic                               m_axis_tlast
);

    logic                                              out_stalled;
    logic                                              mid_taken;
    logic [des_ks_pkg::SUBKEY_W+des_ks_pkg::NUM_W:0]   beat;
    logic                                              num_ok;
    logic                                              final_num;
    logic [des_ks_pkg::NUM_W-1:0]                      num_inc;

    assign out_stalled = m_axis_tvalid && !m_axis_tready;
    assign mid_taken   = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
    assign beat        = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign num_ok      = (m_axis_tuser != '0) &&
                         (m_axis_tuser <= des_ks_pkg::NUM_W'(des_ks_pkg::ROUNDS));
    assign final_num   = (m_axis_tuser == des_ks_pkg::NUM_W'(des_ks_pkg::ROUNDS));
    assign num_inc     = m_axis_tuser + 1'b1;

    // a stalled beat keeps its contents
    `DKS_ASSERT_NEXT(a_hold_stalled, out_stalled, m_axis_tvalid && $stable(beat))

    // round number stays within 1 to 16
    `DKS_ASSERT_NOW(a_round_range, m_axis_tvalid, num_ok)

    // tlast marks exactly the final round
    `DKS_ASSERT_NOW(a_last_on_final, m_axis_tvalid, m_axis_tlast == final_num)

    // rounds of one key follow without gaps once a beat is taken
    `DKS_ASSERT_NEXT(a_round_follows, mid_taken, m_axis_tvalid && (m_axis_tuser == $past(num_inc)))

endmodule

bind des_key_schedule_unit des_ks_checker u_des_ks_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
